FILE: rtl/core/cbma_pkg.sv
// types and constants shared by the centred box moving average block
// no dependencies; imported by the divider and the top level

package cbma_pkg;

  localparam int DATA_W         = 32;
  localparam int SUM_W          = 40;
  localparam int HW_W           = 6;
  localparam int FULL_W         = HW_W + 1;
  localparam int DIV_RADIX_BITS = 4;

  localparam logic [HW_W-1:0] HALF_WIDTH_RESET = HW_W'(4);

  typedef struct packed {
    logic signed [DATA_W-1:0] sample_x;
    logic signed [DATA_W-1:0] sample_y;
    logic                     last_sample;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] out_x;
    logic signed [DATA_W-1:0] out_mean;
    logic                     last_result;
  } out_item_t;

  typedef struct packed {
    logic                    start;
    logic signed [SUM_W-1:0] dividend;
    logic [FULL_W-1:0]       divisor;
  } div_req_t;

endpackage

FILE: rtl/core/cbma_stream_if.sv
// valid/ready stream channel carrying one payload per transaction
// payload type given by parameter; no package dependency

interface cbma_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

FILE: rtl/core/cbma_ring_mem.sv
// single write port, single registered read port sample ring
// read returns the old contents when the same entry is written in that cycle

module cbma_ring_mem #(
  parameter int DEPTH = 128,
  parameter int WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/cbma_div.sv
// sequential signed divider of the window sum by the window length
// uses cbma_pkg; radix 2^DIV_RADIX_BITS restoring steps, truncates toward zero

module cbma_div
  import cbma_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  div_req_t          req_i,
  output logic              busy_o,
  output logic [DATA_W-1:0] quotient_o
);

  localparam int STEPS = SUM_W / DIV_RADIX_BITS;
  localparam int CW    = $clog2(STEPS + 1);

  logic              busy_q, busy_d;
  logic [CW-1:0]     ctr_q, ctr_d;
  logic              neg_q, neg_d;
  logic [FULL_W-1:0] div_q, div_d;
  logic [FULL_W-1:0] rem_q, rem_d;
  logic [SUM_W-1:0]  quo_q, quo_d;
  logic [FULL_W-1:0] rem_step;
  logic [SUM_W-1:0]  quo_step;
  logic [DATA_W-1:0] mag;

  always_comb begin : step_calc
    logic [FULL_W:0] trial;
    trial    = '0;
    rem_step = rem_q;
    quo_step = quo_q;
    for (int i = 0; i < DIV_RADIX_BITS; i++) begin
      trial    = {rem_step, quo_step[SUM_W-1]};
      quo_step = {quo_step[SUM_W-2:0], 1'b0};
      if (trial >= {1'b0, div_q}) begin
        rem_step    = FULL_W'(trial - {1'b0, div_q});
        quo_step[0] = 1'b1;
      end else begin
        rem_step = trial[FULL_W-1:0];
      end
    end
  end

  always_comb begin
    busy_d = busy_q;
    ctr_d  = ctr_q;
    neg_d  = neg_q;
    div_d  = div_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      ctr_d  = '0;
      neg_d  = req_i.dividend[SUM_W-1];
      div_d  = req_i.divisor;
      rem_d  = '0;
      quo_d  = req_i.dividend[SUM_W-1] ? -req_i.dividend : req_i.dividend;
    end else if (busy_q) begin
      rem_d = rem_step;
      quo_d = quo_step;
      ctr_d = ctr_q + CW'(1);
      if (ctr_q == CW'(STEPS - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      ctr_q  <= '0;
      neg_q  <= 1'b0;
      div_q  <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
    end else begin
      busy_q <= busy_d;
      ctr_q  <= ctr_d;
      neg_q  <= neg_d;
      div_q  <= div_d;
      rem_q  <= rem_d;
      quo_q  <= quo_d;
    end
  end

  assign mag        = quo_q[DATA_W-1:0];
  assign quotient_o = neg_q ? -mag : mag;
  assign busy_o     = busy_q;

endmodule

FILE: rtl/core/centered_box_moving_average.sv
// Centred box moving average with edge replication over a stream of Q16.16 (x, y) samples.
// Each y is replaced by the truncated mean of the 2w+1 samples centred on it; results lag
// the input by w samples and the transaction marked last releases up to w+1 remaining results.
// x and y are kept in two rings of STORE_DEPTH entries; a 40-bit running sum is updated with
// one ring read per sample and divided by 2w+1 in a radix-16 divider. The first sample of a
// sequence, and the first after a change of w, rebuild the sum from the ring. Input is taken
// one transaction at a time; a finished result waits in the output register without holding
// up the next input.
// Depends on cbma_pkg, cbma_stream_if, cbma_ring_mem and cbma_div.

module centered_box_moving_average
  import cbma_pkg::*;
#(
  parameter int MAX_HALF_WIDTH = 63,
  parameter int STORE_DEPTH    = 128
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [HW_W-1:0]     cfg_wdata_i,
  cbma_stream_if.sink         in_i,
  cbma_stream_if.source       out_o
);

  localparam int AW       = $clog2(STORE_DEPTH);
  localparam int W_CAP_D  = (STORE_DEPTH - 1) / 2;
  localparam int W_CAP    = (MAX_HALF_WIDTH < W_CAP_D) ? MAX_HALF_WIDTH : W_CAP_D;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UPDATE,
    S_SWEEP,
    S_CENTER,
    S_DIV,
    S_SHIFT
  } state_e;

  state_e            state_q, state_d;
  logic [HW_W-1:0]   hw_q, hw_d;
  logic [AW-1:0]     wr_slot_q, wr_slot_d;
  logic [AW-1:0]     cur_q, cur_d;
  logic [FULL_W-1:0] seen_q, seen_d;
  logic [FULL_W-1:0] cnt_q, cnt_d;
  logic [FULL_W-1:0] age_q, age_d;
  logic [HW_W-1:0]   w_q, w_d;
  logic [HW_W-1:0]   sum_w_q, sum_w_d;
  logic [HW_W-1:0]   ctr_q, ctr_d;
  logic [DATA_W-1:0] first_q, first_d;
  logic [DATA_W-1:0] ynew_q, ynew_d;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic              last_q, last_d;
  logic              rem_real_q, rem_real_d;
  logic              pend_q, pend_d;
  logic              pend_mem_q, pend_mem_d;
  logic              shift_mem_q, shift_mem_d;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_data_q, out_data_d;

  logic              mem_we;
  logic              x_ren, y_ren;
  logic [AW-1:0]     x_raddr, y_raddr;
  logic [DATA_W-1:0] x_rd, y_rd;
  div_req_t          div_req;
  logic              div_busy;
  logic [DATA_W-1:0] div_quo;

  logic [HW_W-1:0]   w_eff;
  logic [FULL_W-1:0] full_eff;
  logic [FULL_W:0]   seen_inc;
  logic [FULL_W-1:0] cnt_new;
  logic [HW_W-1:0]   top_c;
  logic [FULL_W-1:0] drop_age;
  logic              emit;
  logic              out_free;

  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base, input logic [AW:0] age);
    logic [AW:0] base_w;
    logic [AW:0] wrapped;
    base_w = {1'b0, base};
    if (age > base_w) begin
      wrapped = base_w + (AW+1)'(STORE_DEPTH) - age;
    end else begin
      wrapped = base_w - age;
    end
    return wrapped[AW-1:0];
  endfunction

  cbma_ring_mem #(
    .DEPTH (STORE_DEPTH),
    .WIDTH (DATA_W)
  ) u_x_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (wr_slot_q),
    .wdata_i (in_i.data.sample_x),
    .re_i    (x_ren),
    .raddr_i (x_raddr),
    .rdata_o (x_rd)
  );

  cbma_ring_mem #(
    .DEPTH (STORE_DEPTH),
    .WIDTH (DATA_W)
  ) u_y_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (wr_slot_q),
    .wdata_i (in_i.data.sample_y),
    .re_i    (y_ren),
    .raddr_i (y_raddr),
    .rdata_o (y_rd)
  );

  cbma_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .busy_o     (div_busy),
    .quotient_o (div_quo)
  );

  assign w_eff    = (hw_q > HW_W'(W_CAP)) ? HW_W'(W_CAP) : hw_q;
  assign full_eff = {w_eff, 1'b1};
  assign seen_inc = {1'b0, seen_q} + (FULL_W+1)'(1);
  assign cnt_new  = (seen_inc > {1'b0, full_eff}) ? full_eff : seen_inc[FULL_W-1:0];
  assign top_c    = (cnt_q > FULL_W'(w_q)) ? w_q : HW_W'(cnt_q - FULL_W'(1));
  assign emit     = last_q ? (ctr_q <= top_c) : (cnt_q > FULL_W'(w_q));
  assign drop_age = FULL_W'(ctr_q) + FULL_W'(w_q);
  assign out_free = !out_valid_q || out_o.ready;

  always_comb begin
    state_d     = state_q;
    hw_d        = cfg_we_i ? cfg_wdata_i : hw_q;
    wr_slot_d   = wr_slot_q;
    cur_d       = cur_q;
    seen_d      = seen_q;
    cnt_d       = cnt_q;
    age_d       = age_q;
    w_d         = w_q;
    sum_w_d     = sum_w_q;
    ctr_d       = ctr_q;
    first_d     = first_q;
    ynew_d      = ynew_q;
    sum_d       = sum_q;
    last_d      = last_q;
    rem_real_d  = rem_real_q;
    pend_d      = pend_q;
    pend_mem_d  = pend_mem_q;
    shift_mem_d = shift_mem_q;
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q && !out_o.ready;
    mem_we      = 1'b0;
    x_ren       = 1'b0;
    x_raddr     = '0;
    y_ren       = 1'b0;
    y_raddr     = '0;
    div_req     = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          mem_we     = 1'b1;
          // sample leaving the window, read before this write lands
          y_ren      = 1'b1;
          y_raddr    = slot_of(wr_slot_q, (AW+1)'(full_eff));
          w_d        = w_eff;
          cnt_d      = cnt_new;
          last_d     = in_i.data.last_sample;
          ynew_d     = in_i.data.sample_y;
          cur_d      = wr_slot_q;
          rem_real_d = (seen_q == full_eff);
          if (seen_q == '0) begin
            first_d = in_i.data.sample_y;
          end
          seen_d    = in_i.data.last_sample ? '0 : cnt_new;
          wr_slot_d = (wr_slot_q == AW'(STORE_DEPTH - 1)) ? '0 : wr_slot_q + AW'(1);
          if (seen_q == '0 || w_eff != sum_w_q) begin
            state_d = S_SWEEP;
            sum_d   = '0;
            age_d   = '0;
            pend_d  = 1'b0;
            sum_w_d = w_eff;
          end else begin
            state_d = S_UPDATE;
          end
        end
      end

      S_UPDATE: begin
        sum_d = sum_q + SUM_W'($signed(ynew_q))
                - SUM_W'($signed(rem_real_q ? y_rd : first_q));
        ctr_d   = w_q;
        state_d = S_CENTER;
      end

      S_SWEEP: begin
        if (pend_q) begin
          sum_d = sum_q + SUM_W'($signed(pend_mem_q ? y_rd : first_q));
        end
        if (age_q <= {w_q, 1'b0}) begin
          y_ren      = age_q < cnt_q;
          y_raddr    = slot_of(cur_q, (AW+1)'(age_q));
          pend_d     = 1'b1;
          pend_mem_d = age_q < cnt_q;
          age_d      = age_q + FULL_W'(1);
        end else begin
          pend_d  = 1'b0;
          ctr_d   = w_q;
          state_d = S_CENTER;
        end
      end

      S_CENTER: begin
        if (emit) begin
          div_req.start    = 1'b1;
          div_req.dividend = sum_q;
          div_req.divisor  = {w_q, 1'b1};
          x_ren            = 1'b1;
          x_raddr          = slot_of(cur_q, (AW+1)'(ctr_q));
          state_d          = S_DIV;
        end else if (last_q && ctr_q != '0) begin
          shift_mem_d = drop_age < cnt_q;
          y_ren       = drop_age < cnt_q;
          y_raddr     = slot_of(cur_q, (AW+1)'(drop_age));
          state_d     = S_SHIFT;
        end else begin
          state_d = S_IDLE;
        end
      end

      S_DIV: begin
        if (!div_busy && out_free) begin
          out_valid_d            = 1'b1;
          out_data_d.out_x       = x_rd;
          out_data_d.out_mean    = div_quo;
          out_data_d.last_result = last_q && ctr_q == '0;
          if (last_q && ctr_q != '0) begin
            shift_mem_d = drop_age < cnt_q;
            y_ren       = drop_age < cnt_q;
            y_raddr     = slot_of(cur_q, (AW+1)'(drop_age));
            state_d     = S_SHIFT;
          end else begin
            state_d = S_IDLE;
          end
        end
      end

      S_SHIFT: begin
        // centre moves one step towards the newest sample, which repeats past the end
        sum_d = sum_q - SUM_W'($signed(shift_mem_q ? y_rd : first_q))
                + SUM_W'($signed(ynew_q));
        ctr_d   = ctr_q - HW_W'(1);
        state_d = S_CENTER;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      hw_q        <= HALF_WIDTH_RESET;
      wr_slot_q   <= '0;
      cur_q       <= '0;
      seen_q      <= '0;
      cnt_q       <= '0;
      age_q       <= '0;
      w_q         <= '0;
      sum_w_q     <= '0;
      ctr_q       <= '0;
      first_q     <= '0;
      ynew_q      <= '0;
      sum_q       <= '0;
      last_q      <= 1'b0;
      rem_real_q  <= 1'b0;
      pend_q      <= 1'b0;
      pend_mem_q  <= 1'b0;
      shift_mem_q <= 1'b0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      state_q     <= state_d;
      hw_q        <= hw_d;
      wr_slot_q   <= wr_slot_d;
      cur_q       <= cur_d;
      seen_q      <= seen_d;
      cnt_q       <= cnt_d;
      age_q       <= age_d;
      w_q         <= w_d;
      sum_w_q     <= sum_w_d;
      ctr_q       <= ctr_d;
      first_q     <= first_d;
      ynew_q      <= ynew_d;
      sum_q       <= sum_d;
      last_q      <= last_d;
      rem_real_q  <= rem_real_d;
      pend_q      <= pend_d;
      pend_mem_q  <= pend_mem_d;
      shift_mem_q <= shift_mem_d;
      out_valid_q <= out_valid_d;
      out_data_q  <= out_data_d;
    end
  end

  assign in_i.ready  = (state_q == S_IDLE);
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

endmodule
